### rtl/fifo_writeback_sector_cache_tags_assert.svh
// Assertion macros for the sector cache tag controller.
`ifndef FIFO_WRITEBACK_SECTOR_CACHE_TAGS_ASSERT_SVH
`define FIFO_WRITEBACK_SECTOR_CACHE_TAGS_ASSERT_SVH

`ifndef SYNTHESIS
`define FWSCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define FWSCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FWSCT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FWSCT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/fwsct_pkg.sv
// Shared types and constants for the sector cache tag controller.
`default_nettype none

package fwsct_pkg;

    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic take_hit;
        logic take_miss;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;
        logic scan_done;
    } t_status;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                need_fill;
        logic                need_write_back;
        logic [SECTOR_W-1:0] victim_sector;
    } t_result;

endpackage

`default_nettype wire

### rtl/fwsct_ctrl.sv
// Sequencer for lookup, miss handling and commit of one access.
`default_nettype none

module fwsct_ctrl (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    input  wire                logic i_out_free,
    input  wire                fwsct_pkg::t_status i_status,
    output fwsct_pkg::t_cmd    o_cmd,
    output logic               o_busy
);
    import fwsct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (i_status.match) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_COMMIT;
                end else if (i_status.scan_done) begin
                    o_cmd.take_miss = 1'b1;
                    n_state         = ST_COMMIT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_COMMIT: begin
                // hold until the output register can take the result
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

### rtl/fwsct_dp.sv
// Tag RAM, dirty bits, fill count and eviction pointer with scan compare.
`default_nettype none
`include "fifo_writeback_sector_cache_tags_assert.svh"

module fwsct_dp #(
    parameter int SLOTS = 64
) (
    input  wire                logic                           i_clk,
    input  wire                logic                           i_rst_n,
    input  wire                logic                           i_action,
    input  wire                logic [fwsct_pkg::SECTOR_W-1:0] i_sector,
    input  wire                fwsct_pkg::t_cmd                i_cmd,
    output fwsct_pkg::t_status o_status,
    output fwsct_pkg::t_result o_result
);
    import fwsct_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SECTOR_W-1:0] r_tag_mem [SLOTS];
    logic [SECTOR_W-1:0] r_rd_tag;
    logic [IW-1:0]       r_rd_idx;
    logic                r_rd_vld;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_evict;
    logic [SLOTS-1:0]    r_dirty;
    logic                r_action;
    logic [SECTOR_W-1:0] r_sector;
    logic                r_hit;
    logic                r_full;
    logic [IW-1:0]       r_chosen;

    logic          w_more;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic          w_is_full;
    logic          w_wb;

    assign w_more    = (r_idx < r_count);
    assign w_is_full = (r_count == CW'(SLOTS));
    assign w_rd_en   = i_cmd.take_miss || (i_cmd.scan && w_more);
    // the victim read shares the single read port with the scan
    assign w_rd_addr = i_cmd.take_miss ? r_evict : r_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_hit) begin
            r_tag_mem[r_chosen] <= r_sector;
        end
        if (w_rd_en) begin
            r_rd_tag <= r_tag_mem[w_rd_addr];
        end
    end

    // item payload and per-access decisions
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_action <= i_action;
            r_sector <= i_sector;
        end
        if (i_cmd.scan && w_more) begin
            r_rd_idx <= r_idx[IW-1:0];
        end
        if (i_cmd.take_hit) begin
            r_hit    <= 1'b1;
            r_full   <= 1'b0;
            r_chosen <= r_rd_idx;
        end else if (i_cmd.take_miss) begin
            r_hit    <= 1'b0;
            r_full   <= w_is_full;
            r_chosen <= w_is_full ? r_evict : r_count[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_count  <= '0;
            r_evict  <= '0;
            r_dirty  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= w_more;
                if (w_more) begin
                    r_idx <= CW'(r_idx + 1'b1);
                end
            end
            if (i_cmd.commit) begin
                if (r_hit) begin
                    r_dirty[r_chosen] <= r_dirty[r_chosen] | r_action;
                end else begin
                    r_dirty[r_chosen] <= r_action;
                    if (r_full) begin
                        r_evict <= (r_chosen == IW'(SLOTS - 1)) ? '0 : IW'(r_chosen + 1'b1);
                    end else begin
                        r_count <= CW'(r_count + 1'b1);
                    end
                end
            end
        end
    end

    // scan is over once every filled slot has been read and compared
    assign o_status.match     = r_rd_vld && (r_rd_tag == r_sector);
    assign o_status.scan_done = !r_rd_vld && !w_more;

    assign w_wb = !r_hit && r_full && r_dirty[r_chosen];

    assign o_result.hit             = r_hit;
    assign o_result.slot            = SLOT_W'(r_chosen);
    assign o_result.need_fill       = !r_hit;
    assign o_result.need_write_back = w_wb;
    assign o_result.victim_sector   = w_wb ? r_rd_tag : '0;

    `FWSCT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(SLOTS))
    `FWSCT_ASSERT_IMP(a_evict_idle_until_full, i_clk, i_rst_n, !w_is_full, r_evict == '0)
    `FWSCT_ASSERT_NXT(a_fill_advances_count, i_clk, i_rst_n, i_cmd.commit && !r_hit && !r_full,
                      r_count == CW'($past(r_count) + 1'b1))
    `FWSCT_ASSERT_IMP(a_wb_only_when_full, i_clk, i_rst_n, i_cmd.commit && w_wb,
                      r_count == CW'(SLOTS))

endmodule

`default_nettype wire

### rtl/fifo_writeback_sector_cache_tags.sv
// Top level of the write-back sector cache tag controller with FIFO replacement.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_action, i_sector
//  out     | output    | o_out_valid / i_out_stall  | o_hit, o_slot, o_need_fill,
//          |           |                            | o_need_write_back, o_victim_sector
//
// One access at a time. The tag RAM has one read port and is scanned one slot per
// cycle over the filled slots, and the scan ends at the first slot whose tag matches.
// Reset (synchronous) empties the cache: fill count, eviction pointer and dirty bits clear.
// A held result in the output register lets the next item be accepted and scanned;
// only its commit waits for the output register to free up.
`default_nettype none

module fifo_writeback_sector_cache_tags #(
    parameter int SLOTS = 64
) (
    input  wire  logic                           i_clk,
    input  wire  logic                           i_rst_n,
    input  wire  logic                           i_in_valid,
    output logic                                 o_in_stall,
    input  wire  logic                           i_action,
    input  wire  logic [fwsct_pkg::SECTOR_W-1:0] i_sector,
    output logic                                 o_out_valid,
    input  wire  logic                           i_out_stall,
    output logic                                 o_hit,
    output logic [fwsct_pkg::SLOT_W-1:0]         o_slot,
    output logic                                 o_need_fill,
    output logic                                 o_need_write_back,
    output logic [fwsct_pkg::SECTOR_W-1:0]       o_victim_sector
);
    import fwsct_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;
    logic    w_busy;
    logic    w_out_free;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    assign w_out_free = !r_out_valid || !i_out_stall;

    fwsct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    fwsct_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_action (i_action),
        .i_sector (i_sector),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.commit) begin
            r_out <= w_result;
        end
    end

    assign o_in_stall        = w_busy || !i_rst_n;
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_out.hit;
    assign o_slot            = r_out.slot;
    assign o_need_fill       = r_out.need_fill;
    assign o_need_write_back = r_out.need_write_back;
    assign o_victim_sector   = r_out.victim_sector;

endmodule

`default_nettype wire

### test/fifo_writeback_sector_cache_tags_test.sv
// Self-checking testbench for the FIFO-replacement write-back sector cache tag controller.
module fifo_writeback_sector_cache_tags_test;

    localparam int SLOTS          = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOT_SECTORS    = 96;
    localparam int MAX_REPORTS    = 100;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               i_action    = ACT_READ;
    logic [fwsct_pkg::SECTOR_W-1:0]     i_sector    = '0;
    logic                               i_out_stall = 1'b0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic                               o_hit;
    logic [fwsct_pkg::SLOT_W-1:0]       o_slot;
    logic                               o_need_fill;
    logic                               o_need_write_back;
    logic [fwsct_pkg::SECTOR_W-1:0]     o_victim_sector;

    fifo_writeback_sector_cache_tags #(.SLOTS(SLOTS)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_sector          (i_sector),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hit             (o_hit),
        .o_slot            (o_slot),
        .o_need_fill       (o_need_fill),
        .o_need_write_back (o_need_write_back),
        .o_victim_sector   (o_victim_sector)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the cache directory
    logic [31:0] cache_tag   [SLOTS];
    bit          cache_valid [SLOTS];
    bit          cache_dirty [SLOTS];
    int          fill_count = 0;
    int          evict_ptr  = 0;

    fwsct_pkg::t_result pending_results[$];
    fwsct_pkg::t_result want;

    logic [31:0] hot_set [HOT_SECTORS];

    bit idle_on        = 1'b1;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int error_count    = 0;
    int access_count   = 0;
    int hit_count      = 0;
    int fill_count_tot = 0;
    int writeback_count = 0;

    function automatic int find_slot(input logic [31:0] sec);
        for (int i = 0; i < SLOTS; i++)
            if (cache_valid[i] && cache_tag[i] == sec)
                return i;
        return -1;
    endfunction

    function automatic fwsct_pkg::t_result predict_access(input logic act,
                                                         input logic [31:0] sec);
        fwsct_pkg::t_result r;
        int idx;
        r = '0;
        idx = find_slot(sec);
        if (idx >= 0) begin
            r.hit = 1'b1;
        end else begin
            r.need_fill = 1'b1;
            if (fill_count < SLOTS) begin
                idx = fill_count;
                fill_count++;
            end else begin
                idx = evict_ptr;
                if (cache_dirty[idx]) begin
                    r.need_write_back = 1'b1;
                    r.victim_sector   = cache_tag[idx];
                end
                evict_ptr = (evict_ptr + 1) % SLOTS;
            end
            cache_tag[idx]   = sec;
            cache_valid[idx] = 1'b1;
            cache_dirty[idx] = 1'b0;
        end
        if (act == ACT_WRITE)
            cache_dirty[idx] = 1'b1;
        r.slot = idx[fwsct_pkg::SLOT_W-1:0];
        return r;
    endfunction

    // a sector that is not cached right now
    function automatic logic [31:0] fresh_sector();
        logic [31:0] sec;
        sec = $urandom;
        while (find_slot(sec) >= 0)
            sec = $urandom;
        return sec;
    endfunction

    task automatic send_access(input logic act, input logic [31:0] sec);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_sector   <= sec;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_access(act, sec));
        access_count++;
        if (pending_results[$].hit) hit_count++;
        else fill_count_tot++;
        if (pending_results[$].need_write_back) writeback_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic random_action();
        return ($urandom_range(0, 9) < 4) ? ACT_WRITE : ACT_READ;
    endfunction

    // mostly a hot set a bit larger than the cache, so hits and evictions mix
    task automatic send_mixed();
        int pick;
        int k;
        logic [31:0] sec;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            sec = hot_set[$urandom_range(0, HOT_SECTORS-1)];
        end else if (pick < 80) begin
            k = $urandom_range(0, HOT_SECTORS-1);
            hot_set[k] = $urandom;
            sec = hot_set[k];
        end else if (pick < 90) begin
            sec = $urandom;
        end else begin
            sec = $urandom_range(0, 15);
        end
        send_access(random_action(), sec);
    endtask

    task automatic test_extremes();
        send_access(ACT_READ,  32'h0000_0000);
        send_access(ACT_WRITE, 32'hFFFF_FFFF);
        send_access(ACT_READ,  32'hFFFF_FFFF);
        send_access(ACT_WRITE, 32'h0000_0000);
        send_access(ACT_READ,  32'h0000_0000);    // read hit keeps the dirty mark
        send_access(ACT_WRITE, 32'h8000_0000);
        send_access(ACT_READ,  32'h7FFF_FFFF);
        send_access(ACT_WRITE, 32'h5555_5555);
        send_access(ACT_READ,  32'hAAAA_AAAA);
        send_access(ACT_READ,  32'h0000_0001);
        send_access(ACT_READ,  32'hFFFF_FFFE);
        send_access(ACT_READ,  32'h8000_0000);
        send_access(ACT_WRITE, 32'h5555_5555);
    endtask

    task automatic test_fill_and_evict();
        while (fill_count < SLOTS)
            send_access(random_action(), fresh_sector());
        // two full rounds of misses: every old slot is evicted, clean or dirty
        repeat (2 * SLOTS)
            send_access(random_action(), fresh_sector());
        send_access(ACT_READ, 32'h0000_0000);
    endtask

    task automatic test_drain_pause();
        repeat (2) begin
            repeat (20) send_mixed();
            wait_drained();
        end
    endtask

    task automatic test_random_mix();
        repeat (12) begin
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (100) send_mixed();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (150) send_mixed();
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] got_val);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, got_val);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual slot %h",
                             $time, o_slot);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit)
                    report_field("hit", 32'(want.hit), 32'(o_hit));
                if (o_slot !== want.slot)
                    report_field("slot", 32'(want.slot), 32'(o_slot));
                if (o_need_fill !== want.need_fill)
                    report_field("need_fill", 32'(want.need_fill), 32'(o_need_fill));
                if (o_need_write_back !== want.need_write_back)
                    report_field("need_write_back", 32'(want.need_write_back),
                                 32'(o_need_write_back));
                if (o_victim_sector !== want.victim_sector)
                    report_field("victim_sector", want.victim_sector, o_victim_sector);
            end
        end
    end

    // receiver back-pressure in bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_results.size());
            $display("fifo_writeback_sector_cache_tags regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < HOT_SECTORS; i++)
            hot_set[i] = (i < 32) ? i : $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_fill_and_evict();
        test_drain_pause();
        test_random_mix();
        test_no_idle();

        wait_drained();
        repeat (SLOTS + 16) @(posedge i_clk);

        $display("Covered %0d accesses: %0d hits, %0d misses, %0d dirty write-backs,",
                 access_count, hit_count, fill_count_tot, writeback_count);
        $display("over cold fill, FIFO eviction and random traffic with and without stalls.");
        if (error_count == 0) begin
            $display("fifo_writeback_sector_cache_tags regression: pass");
        end else begin
            $display("fifo_writeback_sector_cache_tags regression: fail");
        end
        $finish;
    end

endmodule
